>>> sv/assert_macros.svh
// assertion macros shared by the checker files
// expects clk and rst_n to be visible where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the cycle after the antecedent
`define SBB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbb assertion failed");

// consequent must hold in the same cycle as the antecedent
`define SBB_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbb assertion failed");

`endif

>>> sv/sbb_pkg.sv
// shared types and fixed constants of the box blur mask block
// no dependencies
package sbb_pkg;

    // configuration port geometry
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    // configuration register widths and reset values
    localparam int FRAME_WIDTH_W  = 11;
    localparam int FRAME_HEIGHT_W = 16;
    localparam int KERNEL_SIZE_W  = 4;

    localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RST  = 11'd1024;
    localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 16'd1;
    localparam logic [KERNEL_SIZE_W-1:0]  KERNEL_SIZE_RST  = 4'd1;

    // register index taken from the word address
    typedef enum logic [1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_KERNEL_SIZE  = 2'd2
    } reg_idx_t;

    // command codes of an input word
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_FLUSH  = 1'b1;

    // control of the sample window chain
    typedef struct packed {
        logic step;
        logic clear;
    } win_ctrl_t;

endpackage

>>> sv/sbb_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module sbb_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/sbb_cell.sv
// one cell of the sample window chain, holds one sample of the row
// depends on sbb_pkg
module sbb_cell #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sbb_pkg::win_ctrl_t     ctrl,
    input  logic [SAMPLE_BITS-1:0] d,
    output logic [SAMPLE_BITS-1:0] q
);

    logic [SAMPLE_BITS-1:0] q_reg;

    // clear at row end or frame restart, take the neighbour's sample on a step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= '0;
        end
        else if (ctrl.clear)
        begin
            q_reg <= '0;
        end
        else if (ctrl.step)
        begin
            q_reg <= d;
        end
    end

    assign q = q_reg;

endmodule

>>> sv/sbb_window.sv
// chain of sample cells with a running horizontal box sum
// depends on sbb_pkg and sbb_cell
module sbb_window #(
    parameter int SAMPLE_BITS = 16,
    parameter int MAX_HALF    = 7,
    localparam int WIN    = 2 * MAX_HALF + 1,
    localparam int HALF_W = (MAX_HALF > 0) ? $clog2(MAX_HALF + 1) : 1,
    localparam int RSUM_W = SAMPLE_BITS + $clog2(WIN)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sbb_pkg::win_ctrl_t     ctrl,
    input  logic [HALF_W-1:0]      half,
    input  logic [SAMPLE_BITS-1:0] value,
    output logic [RSUM_W-1:0]      row_sum
);

    localparam int TAP_W = (WIN > 1) ? $clog2(WIN) : 1;

    logic [SAMPLE_BITS-1:0] tap [WIN];
    logic [SAMPLE_BITS-1:0] old;
    logic [TAP_W-1:0]       old_idx;
    logic [RSUM_W-1:0]      acc_reg;
    logic [RSUM_W:0]        acc_wide;

    // row of cells, cell 0 holds the previous sample
    for (genvar k = 0; k < WIN; k++)
    begin : g_cell
        if (k == 0)
        begin : g_head
            sbb_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
                .clk  (clk),
                .rst_n(rst_n),
                .ctrl (ctrl),
                .d    (value),
                .q    (tap[k])
            );
        end
        else
        begin : g_body
            sbb_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
                .clk  (clk),
                .rst_n(rst_n),
                .ctrl (ctrl),
                .d    (tap[k-1]),
                .q    (tap[k])
            );
        end
    end

    // sample leaving the window, 2h+1 places behind the new one
    assign old_idx  = TAP_W'({half, 1'b0});
    assign old      = tap[old_idx];
    assign acc_wide = (RSUM_W+1)'(acc_reg) + (RSUM_W+1)'(value) - (RSUM_W+1)'(old);
    assign row_sum  = acc_wide[RSUM_W-1:0];

    // running sum of the window
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.clear)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.step)
        begin
            acc_reg <= row_sum;
        end
    end

endmodule

>>> sv/sbb_div.sv
// restoring divider, one quotient bit per cycle
// no dependencies
module sbb_div #(
    parameter int Q_W   = 16,
    parameter int NUM_W = 26,
    parameter int DEN_W = 9
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [Q_W-1:0]   quotient,
    output logic             done
);

    localparam int REM_W = DEN_W + 1;
    localparam int CNT_W = $clog2(Q_W + 1);

    logic [REM_W-1:0] rem_reg;
    logic [Q_W-1:0]   low_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [REM_W-1:0] trial;
    logic             fits;
    logic [REM_W-1:0] rem_next;

    // one trial subtraction
    assign trial    = {rem_reg[REM_W-2:0], low_reg[Q_W-1]};
    assign fits     = trial >= {1'b0, den_reg};
    assign rem_next = fits ? (trial - {1'b0, den_reg}) : trial;

    // iteration control, numerator bits shift out as quotient bits shift in
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            low_reg  <= '0;
            den_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                rem_reg  <= REM_W'(num >> Q_W);
                low_reg  <= num[Q_W-1:0];
                den_reg  <= den;
                cnt_reg  <= CNT_W'(Q_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg <= rem_next;
                low_reg <= {low_reg[Q_W-2:0], fits};
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quotient = low_reg;
    assign done     = done_reg;

endmodule

>>> sv/separable_box_blur_mask.sv
// edge normalised box blur of a mask frame, samples in raster order
// an item passes S_CHECK and S_TEST when it releases no word; when it releases one,
// the clipped box is read from the line ram one row a cycle (vc = rows in the box),
// then divided bit-serially; a row's last sample first adds h zero steps of tail sums
// reset: registers back to width 1024, height 1, kernel 1, counters and window cleared
// the line ram is not cleared, only rows written in the current frame are read
module separable_box_blur_mask #(
    parameter int MAX_WIDTH   = 1024,
    parameter int MAX_HALF    = 7,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // input words
    input  logic                            item_valid,
    output logic                            item_stall,
    input  logic                            command,
    input  logic [SAMPLE_BITS-1:0]          sample,
    // result words
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic [SAMPLE_BITS-1:0]          blurred,
    output logic                            last_of_frame,
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sbb_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [sbb_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [sbb_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready
);

    import sbb_pkg::*;

    localparam int WIN    = 2 * MAX_HALF + 1;
    localparam int RING   = 2 * MAX_HALF + 2;
    localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WCNT_W = $clog2(MAX_WIDTH + 1);
    localparam int POS_W  = $clog2(MAX_WIDTH + MAX_HALF + 1);
    localparam int C_W    = POS_W + 1;
    localparam int HALF_W = (MAX_HALF > 0) ? $clog2(MAX_HALF + 1) : 1;
    localparam int LINE_W = $clog2(RING);
    localparam int SPAN_W = $clog2(WIN + 1);
    localparam int CNT_W  = $clog2(WIN * WIN + 1);
    localparam int RSUM_W = SAMPLE_BITS + $clog2(WIN);
    localparam int CSUM_W = RSUM_W + $clog2(WIN);
    localparam int NUM_W  = CSUM_W + 2;
    localparam int DEN_W  = CNT_W + 1;
    localparam int DEPTH  = RING * (2 ** COL_W);
    localparam int AW     = LINE_W + COL_W;
    localparam int ROW_W  = FRAME_HEIGHT_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PAD,
        S_CHECK,
        S_TEST,
        S_READ,
        S_DRAIN,
        S_DSTART,
        S_DIV,
        S_PUT
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [FRAME_WIDTH_W-1:0]  cfg_width_reg;
    logic [FRAME_HEIGHT_W-1:0] cfg_height_reg;
    logic [KERNEL_SIZE_W-1:0]  cfg_kernel_reg;
    logic                      cfg_wr;
    logic                      cfg_restart;
    reg_idx_t                  cfg_idx;

    // effective frame geometry
    logic [WCNT_W-1:0]        eff_w;
    logic [ROW_W-1:0]         eff_hgt;
    logic [HALF_W-1:0]        half;
    logic [KERNEL_SIZE_W-1:0] kern_half;
    logic [C_W-1:0]           wlast;
    logic [C_W-1:0]           half_c;
    logic [ROW_W-1:0]         hgt_m1;

    // input position
    logic [COL_W-1:0]  in_col_reg;
    logic [ROW_W-1:0]  in_row_reg;
    logic [LINE_W-1:0] in_line_reg;
    logic              done_reg;

    // tail of a row
    logic [POS_W-1:0]  pad_pos_reg;
    logic [HALF_W-1:0] pad_left_reg;
    logic [LINE_W-1:0] pad_line_reg;

    // output position and box
    logic [COL_W-1:0]  out_col_reg;
    logic [ROW_W-1:0]  out_row_reg;
    logic [LINE_W-1:0] out_line_reg;
    logic [ROW_W-1:0]  need_r_reg;
    logic [COL_W-1:0]  need_c_reg;
    logic [ROW_W-1:0]  rlo_reg;
    logic [COL_W-1:0]  clo_reg;
    logic [HALF_W-1:0] back_reg;
    logic              bad_reg;
    logic              last_reg;

    // column sum and divide
    logic [LINE_W-1:0] rd_line_reg;
    logic [SPAN_W-1:0] rows_left_reg;
    logic              rd_valid_reg;
    logic [CSUM_W-1:0] colsum_reg;
    logic [CNT_W-1:0]  count_reg;

    // result register
    logic                   result_valid_reg;
    logic [SAMPLE_BITS-1:0] blurred_reg;
    logic                   last_out_reg;

    // datapath wires
    logic                   take;
    logic [C_W-1:0]         in_col_c;
    logic                   in_store;
    logic                   row_end;
    logic                   row_last;
    logic [LINE_W-1:0]      in_line_inc;
    logic                   pad_store;
    logic [COL_W-1:0]       pad_col;
    logic [LINE_W-1:0]      out_line_inc;
    logic [LINE_W-1:0]      rd_line_inc;
    logic [ROW_W:0]         oyh;
    logic [C_W-1:0]         oxh;
    logic [ROW_W-1:0]       need_r;
    logic [C_W-1:0]         need_c;
    logic [ROW_W-1:0]       rlo;
    logic [C_W-1:0]         clo;
    logic                   ready;
    logic [SPAN_W-1:0]      vc;
    logic [SPAN_W-1:0]      hc;
    logic [LINE_W-1:0]      first_line;
    logic                   out_free;
    logic                   put;
    logic                   restart;
    win_ctrl_t              win_ctrl;
    logic [SAMPLE_BITS-1:0] win_value;
    logic [RSUM_W-1:0]      row_sum;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    logic [RSUM_W-1:0]      rd_data;
    logic                   div_start;
    logic [NUM_W-1:0]       div_num;
    logic [DEN_W-1:0]       div_den;
    logic [SAMPLE_BITS-1:0] div_q;
    logic                   div_done;

    // configuration port
    assign pready      = 1'b1;
    assign cfg_wr      = psel && penable && pwrite;
    assign cfg_idx     = reg_idx_t'(paddr[3:2]);
    assign cfg_restart = cfg_wr && ((cfg_idx == REG_FRAME_WIDTH)
                                 || (cfg_idx == REG_FRAME_HEIGHT)
                                 || (cfg_idx == REG_KERNEL_SIZE));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_width_reg  <= FRAME_WIDTH_RST;
            cfg_height_reg <= FRAME_HEIGHT_RST;
            cfg_kernel_reg <= KERNEL_SIZE_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_FRAME_WIDTH:  cfg_width_reg  <= pwdata[FRAME_WIDTH_W-1:0];
                REG_FRAME_HEIGHT: cfg_height_reg <= pwdata[FRAME_HEIGHT_W-1:0];
                REG_KERNEL_SIZE:  cfg_kernel_reg <= pwdata[KERNEL_SIZE_W-1:0];
                default:          ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (cfg_idx)
            REG_FRAME_WIDTH:  prdata = CFG_DATA_W'(cfg_width_reg);
            REG_FRAME_HEIGHT: prdata = CFG_DATA_W'(cfg_height_reg);
            REG_KERNEL_SIZE:  prdata = CFG_DATA_W'(cfg_kernel_reg);
            default:          prdata = '0;
        endcase
    end

    // effective geometry, out of range values clamp
    assign kern_half = cfg_kernel_reg >> 1;

    always_comb
    begin
        if (cfg_width_reg == '0)
        begin
            eff_w = WCNT_W'(1);
        end
        else if (32'(cfg_width_reg) > 32'(MAX_WIDTH))
        begin
            eff_w = WCNT_W'(MAX_WIDTH);
        end
        else
        begin
            eff_w = WCNT_W'(cfg_width_reg);
        end
        if (32'(kern_half) > 32'(MAX_HALF))
        begin
            half = HALF_W'(MAX_HALF);
        end
        else
        begin
            half = HALF_W'(kern_half);
        end
    end

    assign eff_hgt = (cfg_height_reg == '0) ? ROW_W'(1) : cfg_height_reg;
    assign hgt_m1  = eff_hgt - ROW_W'(1);
    assign wlast   = C_W'(eff_w) - C_W'(1);
    assign half_c  = C_W'(half);

    // handshake
    assign item_stall = (state_reg != S_IDLE);
    assign take       = item_valid && !item_stall && (command == CMD_SAMPLE) && !done_reg;

    // input side: row sum of the column h behind the newest sample
    assign in_col_c    = C_W'(in_col_reg);
    assign in_store    = in_col_c >= half_c;
    assign row_end     = in_col_c >= wlast;
    assign row_last    = in_row_reg >= hgt_m1;
    assign in_line_inc = (in_line_reg == LINE_W'(RING - 1)) ? '0 : in_line_reg + LINE_W'(1);

    // tail of the row: zeros pushed past the right edge
    assign pad_store = C_W'(pad_pos_reg) >= half_c;
    assign pad_col   = COL_W'(C_W'(pad_pos_reg) - half_c);

    // window chain control
    always_comb
    begin
        win_ctrl.step  = take || ((state_reg == S_PAD) && (pad_left_reg != '0));
        win_ctrl.clear = ((state_reg == S_PAD) && (pad_left_reg == '0)) || restart;
        win_value      = (state_reg == S_IDLE) ? sample : '0;
    end

    sbb_window #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .MAX_HALF   (MAX_HALF)
    ) u_window (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (win_ctrl),
        .half   (half),
        .value  (win_value),
        .row_sum(row_sum)
    );

    // line store write port
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = '0;
        if (take)
        begin
            wr_en   = in_store;
            wr_addr = {in_line_reg, COL_W'(in_col_c - half_c)};
        end
        else if ((state_reg == S_PAD) && (pad_left_reg != '0))
        begin
            wr_en   = pad_store;
            wr_addr = {pad_line_reg, pad_col};
        end
    end

    // line store read port, one row of the box a cycle
    assign rd_en       = (state_reg == S_READ);
    assign rd_addr     = {rd_line_reg, out_col_reg};
    assign rd_line_inc = (rd_line_reg == LINE_W'(RING - 1)) ? '0 : rd_line_reg + LINE_W'(1);

    sbb_ram #(
        .WIDTH(RSUM_W),
        .DEPTH(DEPTH)
    ) u_lines (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(row_sum),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    // clipped box of the next result
    assign oyh    = (ROW_W+1)'(out_row_reg) + (ROW_W+1)'(half);
    assign need_r = (oyh > (ROW_W+1)'(hgt_m1)) ? hgt_m1 : oyh[ROW_W-1:0];
    assign oxh    = C_W'(out_col_reg) + half_c;
    assign need_c = (oxh > wlast) ? wlast : oxh;
    assign rlo    = (out_row_reg >= ROW_W'(half)) ? (out_row_reg - ROW_W'(half)) : '0;
    assign clo    = (C_W'(out_col_reg) >= half_c) ? (C_W'(out_col_reg) - half_c) : '0;

    // readiness and box size
    assign ready = !bad_reg && (done_reg || (need_r_reg < in_row_reg)
                 || ((need_r_reg == in_row_reg) && (need_c_reg < in_col_reg)));
    assign vc    = SPAN_W'(need_r_reg - rlo_reg + ROW_W'(1));
    assign hc    = SPAN_W'(C_W'(need_c_reg) - C_W'(clo_reg) + C_W'(1));

    always_comb
    begin
        if (out_line_reg >= LINE_W'(back_reg))
        begin
            first_line = out_line_reg - LINE_W'(back_reg);
        end
        else
        begin
            first_line = LINE_W'((LINE_W+1)'(out_line_reg) + (LINE_W+1)'(RING)
                                 - (LINE_W+1)'(back_reg));
        end
    end

    assign out_line_inc = (out_line_reg == LINE_W'(RING - 1)) ? '0 : out_line_reg + LINE_W'(1);

    // rounded divide of the box sum by the covered count
    assign div_start = (state_reg == S_DSTART);
    assign div_num   = NUM_W'({colsum_reg, 1'b0}) + NUM_W'(count_reg);
    assign div_den   = {count_reg, 1'b0};

    sbb_div #(
        .Q_W  (SAMPLE_BITS),
        .NUM_W(NUM_W),
        .DEN_W(DEN_W)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .quotient(div_q),
        .done    (div_done)
    );

    // result hand-off, frame restart on the last word or a width, height or kernel write
    assign out_free = !result_valid_reg || !result_stall;
    assign put      = (state_reg == S_PUT) && out_free;
    assign restart  = cfg_restart || (put && last_reg);

    // sequencer, counters and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            in_col_reg       <= '0;
            in_row_reg       <= '0;
            in_line_reg      <= '0;
            done_reg         <= 1'b0;
            pad_pos_reg      <= '0;
            pad_left_reg     <= '0;
            pad_line_reg     <= '0;
            out_col_reg      <= '0;
            out_row_reg      <= '0;
            out_line_reg     <= '0;
            need_r_reg       <= '0;
            need_c_reg       <= '0;
            rlo_reg          <= '0;
            clo_reg          <= '0;
            back_reg         <= '0;
            bad_reg          <= 1'b0;
            last_reg         <= 1'b0;
            rd_line_reg      <= '0;
            rows_left_reg    <= '0;
            rd_valid_reg     <= 1'b0;
            colsum_reg       <= '0;
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
            blurred_reg      <= '0;
            last_out_reg     <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= (state_reg == S_READ);

            // accumulate the column of row sums
            if (rd_valid_reg)
            begin
                colsum_reg <= colsum_reg + CSUM_W'(rd_data);
            end

            // result register drains when taken
            if (result_valid_reg && !result_stall)
            begin
                result_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (item_valid)
                    begin
                        state_reg <= S_CHECK;
                        if (take)
                        begin
                            if (row_end)
                            begin
                                state_reg    <= S_PAD;
                                pad_pos_reg  <= POS_W'(eff_w);
                                pad_left_reg <= half;
                                pad_line_reg <= in_line_reg;
                                in_col_reg   <= '0;
                                if (row_last)
                                begin
                                    in_row_reg  <= '0;
                                    in_line_reg <= '0;
                                    done_reg    <= 1'b1;
                                end
                                else
                                begin
                                    in_row_reg  <= in_row_reg + ROW_W'(1);
                                    in_line_reg <= in_line_inc;
                                end
                            end
                            else
                            begin
                                in_col_reg <= in_col_reg + COL_W'(1);
                            end
                        end
                    end
                end
                S_PAD:
                begin
                    if (pad_left_reg == '0)
                    begin
                        state_reg <= S_CHECK;
                    end
                    else
                    begin
                        pad_pos_reg  <= pad_pos_reg + POS_W'(1);
                        pad_left_reg <= pad_left_reg - HALF_W'(1);
                    end
                end
                S_CHECK:
                begin
                    need_r_reg <= need_r;
                    need_c_reg <= COL_W'(need_c);
                    rlo_reg    <= rlo;
                    clo_reg    <= COL_W'(clo);
                    back_reg   <= HALF_W'(out_row_reg - rlo);
                    bad_reg    <= (C_W'(out_col_reg) > wlast) || (out_row_reg > hgt_m1);
                    last_reg   <= (out_row_reg == hgt_m1) && (C_W'(out_col_reg) == wlast);
                    state_reg  <= S_TEST;
                end
                S_TEST:
                begin
                    if (ready)
                    begin
                        count_reg     <= CNT_W'(hc * vc);
                        rows_left_reg <= vc;
                        rd_line_reg   <= first_line;
                        colsum_reg    <= '0;
                        state_reg     <= S_READ;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_READ:
                begin
                    rd_line_reg   <= rd_line_inc;
                    rows_left_reg <= rows_left_reg - SPAN_W'(1);
                    if (rows_left_reg == SPAN_W'(1))
                    begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    state_reg <= S_DSTART;
                end
                S_DSTART:
                begin
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_PUT;
                    end
                end
                S_PUT:
                begin
                    if (out_free)
                    begin
                        result_valid_reg <= 1'b1;
                        blurred_reg      <= div_q;
                        last_out_reg     <= last_reg;
                        state_reg        <= S_IDLE;
                        if (C_W'(out_col_reg) >= wlast)
                        begin
                            out_col_reg  <= '0;
                            out_row_reg  <= out_row_reg + ROW_W'(1);
                            out_line_reg <= out_line_inc;
                        end
                        else
                        begin
                            out_col_reg <= out_col_reg + COL_W'(1);
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            // a restart wins over the position updates above
            if (restart)
            begin
                in_col_reg   <= '0;
                in_row_reg   <= '0;
                in_line_reg  <= '0;
                out_col_reg  <= '0;
                out_row_reg  <= '0;
                out_line_reg <= '0;
                done_reg     <= 1'b0;
            end
        end
    end

    assign result_valid  = result_valid_reg;
    assign blurred       = blurred_reg;
    assign last_of_frame = last_out_reg;

endmodule

>>> sv/sbb_checker.sv
// port level checks of the box blur mask block, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"

module sbb_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   item_valid,
    input logic                   item_stall,
    input logic                   result_valid,
    input logic                   result_stall,
    input logic [SAMPLE_BITS-1:0] blurred,
    input logic                   last_of_frame
);

    // a stalled result word holds
    `SBB_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(blurred))
    `SBB_ASSERT_NEXT(a_last_hold, result_valid && result_stall, $stable(last_of_frame))

    // an accepted word keeps the block busy for at least the next cycle
    `SBB_ASSERT_NEXT(a_busy_after_accept, item_valid && !item_stall, item_stall)

    // a new result word only appears out of the busy sequence
    `SBB_ASSERT_SAME(a_result_from_busy, $rose(result_valid), $past(item_stall))

endmodule

bind separable_box_blur_mask sbb_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_sbb_checker (.*);

>>> tb/sv/sbb_checker.sv
// checker for the box blur mask block: tracks config writes and accepted words,
// predicts each blurred word and compares it with what the block hands out
// depends on sbb_pkg
module sbb_scoreboard (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    input  logic                           item_stall,
    input  logic                           command,
    input  logic [15:0]                    sample,
    input  logic                           result_valid,
    input  logic                           result_stall,
    input  logic [15:0]                    blurred,
    input  logic                           last_of_frame,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic                           pready,
    input  logic [sbb_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [sbb_pkg::CFG_DATA_W-1:0] pwdata,
    output int                             err_count,
    output int                             pending,
    output int                             owed
);
    import sbb_pkg::*;

    localparam int LINE_W = 1024;
    localparam int HALF_MAX = 7;
    localparam int WIN_N = 2 * HALF_MAX + 1;
    localparam int RING_N = 2 * HALF_MAX + 2;

    typedef struct {
        logic [15:0] blurred;
        logic        last;
    } blur_word_t;

    // shadow registers and frame state
    int unsigned width_reg, height_reg, kernel_reg;
    longint      row_sums [RING_N*LINE_W];
    longint      row_win [WIN_N];
    int          in_col, in_row, out_col, out_row;
    bit          frame_in;
    int          nerr;
    blur_word_t  blur_q [$];

    function automatic int act_width();
        if (width_reg == 0) return 1;
        if (width_reg > LINE_W) return LINE_W;
        return width_reg;
    endfunction

    function automatic int act_height();
        return (height_reg == 0) ? 1 : height_reg;
    endfunction

    function automatic int act_half();
        int h;
        h = kernel_reg / 2;
        return (h > HALF_MAX) ? HALF_MAX : h;
    endfunction

    function automatic void clear_frame();
        foreach (row_win[i]) row_win[i] = 0;
        in_col = 0;
        in_row = 0;
        out_col = 0;
        out_row = 0;
        frame_in = 0;
    endfunction

    // clipped horizontal sum for one column of the current row
    function automatic void store_row_sum(int col, int w, int h);
        int     lo, hi;
        longint acc;
        lo = (col >= h) ? col - h : 0;
        hi = (col + h > w - 1) ? w - 1 : col + h;
        acc = 0;
        for (int c = lo; c <= hi; c++)
            if (c <= in_col && in_col - c < WIN_N) acc += row_win[in_col - c];
        row_sums[(in_row % RING_N)*LINE_W + col] = acc;
    endfunction

    function automatic void absorb_sample(logic [15:0] value);
        int w, ht, h, first;
        w = act_width();
        ht = act_height();
        h = act_half();
        for (int c = WIN_N - 1; c > 0; c--) row_win[c] = row_win[c-1];
        row_win[0] = value;
        if (in_col >= h) store_row_sum(in_col - h, w, h);
        if (in_col + 1 >= w) begin
            first = (in_col >= h) ? in_col - h + 1 : 0;
            for (int c = first; c < w; c++) store_row_sum(c, w, h);
            foreach (row_win[i]) row_win[i] = 0;
            in_col = 0;
            if (in_row + 1 >= ht) begin
                in_row = 0;
                frame_in = 1;
            end
            else
                in_row++;
        end
        else
            in_col++;
    endfunction

    // next blurred word, if its whole box has arrived
    function automatic bit release_word(output blur_word_t word);
        int     w, ht, h, need_r, need_c, rlo, clo;
        longint acc, cnt;
        w = act_width();
        ht = act_height();
        h = act_half();
        need_r = (out_row + h > ht - 1) ? ht - 1 : out_row + h;
        need_c = (out_col + h > w - 1) ? w - 1 : out_col + h;
        if (out_col >= w || out_row >= ht) return 0;
        if (!frame_in && !(need_r < in_row || (need_r == in_row && need_c < in_col)))
            return 0;
        rlo = (out_row >= h) ? out_row - h : 0;
        clo = (out_col >= h) ? out_col - h : 0;
        acc = 0;
        for (int r = rlo; r <= need_r; r++) acc += row_sums[(r % RING_N)*LINE_W + out_col];
        cnt = longint'(need_c - clo + 1) * longint'(need_r - rlo + 1);
        word.blurred = 16'((2*acc + cnt) / (2*cnt));
        word.last = (out_row == ht - 1) && (out_col == w - 1);
        if (word.last)
            clear_frame();
        else if (out_col + 1 >= w) begin
            out_col = 0;
            out_row++;
        end
        else
            out_col++;
        return 1;
    endfunction

    function automatic int words_owed();
        if (!frame_in) return 0;
        return act_width()*act_height() - (out_row*act_width() + out_col);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        blur_word_t want, got;
        if (!rst_n)
        begin
            width_reg = FRAME_WIDTH_RST;
            height_reg = FRAME_HEIGHT_RST;
            kernel_reg = KERNEL_SIZE_RST;
            clear_frame();
            blur_q.delete();
            nerr = 0;
            err_count <= 0;
            pending <= 0;
            owed <= 0;
        end
        else
        begin
            // a width, height or kernel write aborts the frame in progress
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[3:2]))
                    REG_FRAME_WIDTH:  begin width_reg = pwdata[10:0]; clear_frame(); end
                    REG_FRAME_HEIGHT: begin height_reg = pwdata[15:0]; clear_frame(); end
                    REG_KERNEL_SIZE:  begin kernel_reg = pwdata[3:0]; clear_frame(); end
                    default: ;
                endcase
            end
            // accepted input word
            if (item_valid && !item_stall)
            begin
                if (command == CMD_SAMPLE && !frame_in) absorb_sample(sample);
                if (release_word(want)) blur_q.push_back(want);
            end
            // accepted result word
            if (result_valid && !result_stall)
            begin
                got.blurred = blurred;
                got.last = last_of_frame;
                if (blur_q.size() == 0)
                begin
                    $display("%0t unexpected word blurred=%h last=%b", $time, blurred,
                             last_of_frame);
                    nerr++;
                end
                else
                begin
                    want = blur_q.pop_front();
                    if (got.blurred !== want.blurred)
                    begin
                        $display("%0t blurred expected %h actual %h", $time, want.blurred,
                                 got.blurred);
                        nerr++;
                    end
                    if (got.last !== want.last)
                    begin
                        $display("%0t last_of_frame expected %b actual %b", $time,
                                 want.last, got.last);
                        nerr++;
                    end
                end
            end
            err_count <= nerr;
            pending <= blur_q.size();
            owed <= words_owed();
        end
    end

endmodule

>>> tb/sv/tb_separable_box_blur_mask.sv
// top of the box blur mask testbench: clock, reset, register writes and mask frames
// depends on sbb_pkg, sbb_scoreboard and separable_box_blur_mask
module tb_separable_box_blur_mask;
    import sbb_pkg::*;

    localparam int SPARE_REG_IDX = 3;

    logic                  clk;
    logic                  rst_n;
    logic                  item_valid, item_stall, command;
    logic [15:0]           sample;
    logic                  result_valid, result_stall, last_of_frame;
    logic [15:0]           blurred;
    logic                  psel, penable, pwrite, pready;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata, prdata;
    int                    err_count, pending, owed;
    int                    gap_pct, stall_pct;
    int                    sent_words;

    separable_box_blur_mask u_dut (.*);

    sbb_scoreboard u_check (
        .clk(clk), .rst_n(rst_n), .item_valid(item_valid), .item_stall(item_stall),
        .command(command), .sample(sample), .result_valid(result_valid),
        .result_stall(result_stall), .blurred(blurred), .last_of_frame(last_of_frame),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata), .err_count(err_count), .pending(pending),
        .owed(owed)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // receiver back-pressure
    always @(posedge clk)
        result_stall <= ($urandom_range(99) < stall_pct);

    // offer one word and hold it until taken
    task automatic push_word(input logic cmd, input logic [15:0] value);
        if (gap_pct > 0 && $urandom_range(99) < gap_pct)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        item_valid <= 1'b1;
        command <= cmd;
        sample <= value;
        @(posedge clk);
        while (item_stall) @(posedge clk);
        sent_words++;
    endtask

    // register write once the block has gone quiet
    task automatic write_reg(input int idx, input logic [31:0] value);
        item_valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CFG_ADDR_W'(idx * 4);
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    function automatic logic [15:0] pick_sample(bit directed, int n);
        if (directed)
            return (n % 3 == 0) ? 16'h0000 : (n % 3 == 1) ? 16'hFFFF : 16'($urandom);
        if ($urandom_range(9) == 0) return $urandom_range(1) ? 16'hFFFF : 16'h0000;
        return 16'($urandom);
    endfunction

    // one whole frame: samples with stray flush ticks, then the drain
    task automatic run_frame(input int w, input int h, input int k, input bit directed);
        int aw, ah;
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        write_reg(REG_KERNEL_SIZE, k);
        aw = (w == 0) ? 1 : (w > 1024 ? 1024 : w);
        ah = (h == 0) ? 1 : h;
        for (int n = 0; n < aw*ah; n++)
        begin
            if ($urandom_range(99) < 20)
                push_word(CMD_FLUSH, 16'($urandom));
            push_word(CMD_SAMPLE, pick_sample(directed, n));
        end
        // drain; samples sent here are dropped by the block
        do
        begin
            if (owed >= 3 && $urandom_range(3) == 0)
                push_word(CMD_SAMPLE, 16'($urandom));
            else
                push_word(CMD_FLUSH, 16'($urandom));
        end
        while (owed > 0);
    endtask

    initial
    begin
        #20000000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        int w, h, k;
        rst_n = 1'b0;
        item_valid = 1'b0;
        command = CMD_SAMPLE;
        sample = '0;
        result_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        gap_pct = 20;
        stall_pct = 56;
        sent_words = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: pass-through, widest kernel, clipped edges, out-of-range sizes
        run_frame(1, 1, 0, 1);
        run_frame(3, 3, 15, 1);
        run_frame(5, 4, 2, 1);
        run_frame(0, 0, 4, 1);
        run_frame(2, 3, 1, 1);
        // tallest frame: every sample answers at once, cut short by the next frame
        write_reg(REG_FRAME_WIDTH, 1);
        write_reg(REG_FRAME_HEIGHT, 65535);
        write_reg(REG_KERNEL_SIZE, 1);
        for (int n = 0; n < 20; n++) push_word(CMD_SAMPLE, pick_sample(1, n));
        write_reg(SPARE_REG_IDX, $urandom);
        run_frame(4, 2, 3, 1);
        // over-wide row clamps to the line length, cut short by the next frame
        write_reg(REG_FRAME_WIDTH, 2047);
        write_reg(REG_FRAME_HEIGHT, 1);
        write_reg(REG_KERNEL_SIZE, 3);
        for (int n = 0; n < 40; n++) push_word(CMD_SAMPLE, pick_sample(1, n));

        // random frames, mostly small
        while (sent_words < 700)
        begin
            if (sent_words < 250)
            begin
                gap_pct = 20;
                stall_pct = 56;
            end
            else if (sent_words < 500)
            begin
                gap_pct = 56;
                stall_pct = 20;
            end
            else
            begin
                gap_pct = 0;
                stall_pct = 0;
            end
            w = $urandom_range(12, 1);
            h = $urandom_range(6, 1);
            k = $urandom_range(15);
            if ($urandom_range(15) == 0) w = 0;
            if ($urandom_range(15) == 0) h = 0;
            if (w == 0) h = 1;
            run_frame(w, h, k, 0);
        end

        item_valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
